// File: rtl/lwk_pkg.sv
package lwk_pkg;

  localparam int unsigned MaxLen   = 4096;
  localparam int unsigned Alphabet = 256;

  localparam int unsigned SymW  = 8;
  localparam int unsigned SymAw = $clog2(Alphabet);
  localparam int unsigned PosW  = $clog2(MaxLen + 1);
  localparam int unsigned HistAw = $clog2(MaxLen);
  localparam int unsigned CntW  = PosW;
  localparam int unsigned DistW = $clog2(Alphabet + 1) > 9 ? $clog2(Alphabet + 1) : 9;
  localparam int unsigned TgtW  = 9;
  localparam int unsigned BestW = PosW + 1;

  // result word: best_length, window_length, distinct_count, too_long
  localparam int unsigned ResW = BestW + PosW + DistW + 1;
  localparam int unsigned OutW = ((ResW + 7) / 8) * 8;

  // request to the count table
  typedef struct packed {
    logic             rd_en;
    logic [SymAw-1:0] rd_addr;
    logic             wr_en;
    logic [SymAw-1:0] wr_addr;
    logic [CntW-1:0]  wdata;
  } cnt_req_t;

endpackage

// File: rtl/lwk_ram.sv
module lwk_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/lwk_count_table.sv
module lwk_count_table (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   clear_i,
  input  lwk_pkg::cnt_req_t      req_i,
  output logic [lwk_pkg::CntW-1:0] count_o
);

  logic [lwk_pkg::Alphabet-1:0] valid_q;
  logic [lwk_pkg::SymAw-1:0]    raddr_q;
  logic [lwk_pkg::CntW-1:0]     rdata;

  lwk_ram #(
    .Depth(lwk_pkg::Alphabet),
    .Width(lwk_pkg::CntW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (req_i.wr_en),
    .waddr_i(req_i.wr_addr),
    .wdata_i(req_i.wdata),
    .re_i   (req_i.rd_en),
    .raddr_i(req_i.rd_addr),
    .rdata_o(rdata)
  );

  // an entry not written since the last clear reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (clear_i) begin
        valid_q <= '0;
      end
      if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      raddr_q <= req_i.rd_addr;
    end
  end

  assign count_o = valid_q[raddr_q] ? rdata : '0;

endmodule

// File: rtl/longest_window_exact_k_distinct.sv
// A kept symbol goes through S_IDLE (history write, count read), S_INC and S_CHECK; each
// symbol dropped from the window's left end adds S_FETCH and S_DROP (history read, count read,
// count write back); an ignored symbol past the length limit goes straight to S_CHECK.
// Takes one symbol at a time and accepts no new symbol until its result is emitted, which can
// stall on m_axis_tready. Async active-low reset clears the window, the count table (per-entry valid
// flags, no clearing pass) and sets k=1.
module longest_window_exact_k_distinct (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration: target_distinct
  input  logic                        cfg_we_i,
  input  logic [lwk_pkg::TgtW-1:0]    cfg_wdata_i,
  // input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] symbol
  input  logic                        s_axis_tuser,   // first
  // result stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [13:0] best_length, [26:14] span_length, [35:27] distinct_count,
  // [36] too_long, [39:37] zero
  output logic [lwk_pkg::OutW-1:0]    m_axis_tdata
);

  typedef enum logic [2:0] {
    S_IDLE,   // wait for a symbol
    S_INC,    // count data back: bump the count of the new symbol
    S_CHECK,  // decide: drop one more from the left, or emit the result
    S_FETCH,  // history data back: read the count of the leaving symbol
    S_DROP    // count data back: decrement and advance window start
  } state_e;

  state_e state_q, state_d;

  logic [lwk_pkg::PosW-1:0]         pos_q, pos_d;
  logic [lwk_pkg::PosW-1:0]         start_q, start_d;
  logic [lwk_pkg::DistW-1:0]        dist_q, dist_d;
  logic signed [lwk_pkg::BestW-1:0] best_q, best_d;
  logic                             ovf_q, ovf_d;
  logic [lwk_pkg::TgtW-1:0]         tgt_q, tgt_d;
  logic                             out_valid_q, out_valid_d;
  logic [lwk_pkg::OutW-1:0]         out_data_q, out_data_d;
  logic [lwk_pkg::SymW-1:0]         sym_q, sym_d;
  logic                             skip_q, skip_d;

  logic                             accept;
  logic                             can_emit;
  logic [lwk_pkg::PosW-1:0]         pos_base;
  logic [lwk_pkg::PosW-1:0]         win_len;
  logic signed [lwk_pkg::BestW-1:0] win_len_s;
  logic signed [lwk_pkg::BestW-1:0] best_new;
  logic                             need_drop;

  logic                             hist_we;
  logic [lwk_pkg::HistAw-1:0]       hist_waddr;
  logic                             hist_re;
  logic [lwk_pkg::HistAw-1:0]       hist_raddr;
  logic [lwk_pkg::SymW-1:0]         hist_rdata;

  logic                             cnt_clear;
  lwk_pkg::cnt_req_t                cnt_req;
  logic [lwk_pkg::CntW-1:0]         cnt_val;

  // Symbol history: written once per kept symbol, read at the window start
  lwk_ram #(
    .Depth(lwk_pkg::MaxLen),
    .Width(lwk_pkg::SymW)
  ) u_history (
    .clk_i  (clk_i),
    .we_i   (hist_we),
    .waddr_i(hist_waddr),
    .wdata_i(s_axis_tdata[lwk_pkg::SymW-1:0]),
    .re_i   (hist_re),
    .raddr_i(hist_raddr),
    .rdata_o(hist_rdata)
  );

  // Per-symbol counts of the current window
  lwk_count_table u_counts (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clear_i(cnt_clear),
    .req_i  (cnt_req),
    .count_o(cnt_val)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign can_emit      = !out_valid_q || m_axis_tready;

  // a string start restarts positions from zero before this symbol is placed
  assign pos_base  = s_axis_tuser ? '0 : pos_q;
  assign win_len   = pos_q - start_q;
  assign win_len_s = $signed({1'b0, win_len});
  assign need_drop = (dist_q > lwk_pkg::DistW'(tgt_q)) && (start_q < pos_q);

  // best only moves on a kept symbol whose window holds exactly k distinct
  always_comb begin
    best_new = best_q;
    if (!skip_q && (dist_q == lwk_pkg::DistW'(tgt_q)) && (win_len_s > best_q)) begin
      best_new = win_len_s;
    end
  end

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    start_d     = start_q;
    dist_d      = dist_q;
    best_d      = best_q;
    ovf_d       = ovf_q;
    tgt_d       = cfg_we_i ? cfg_wdata_i : tgt_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    sym_d       = sym_q;
    skip_d      = skip_q;
    hist_we     = 1'b0;
    hist_waddr  = pos_base[lwk_pkg::HistAw-1:0];
    hist_re     = 1'b0;
    hist_raddr  = start_q[lwk_pkg::HistAw-1:0];
    cnt_clear   = 1'b0;
    cnt_req     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          sym_d = s_axis_tdata[lwk_pkg::SymW-1:0];
          if (s_axis_tuser) begin
            // new string: drop all window state
            cnt_clear = 1'b1;
            start_d   = '0;
            dist_d    = '0;
            best_d    = '1;
            ovf_d     = 1'b0;
          end
          if (pos_base >= lwk_pkg::PosW'(lwk_pkg::MaxLen)) begin
            // history full: ignore the symbol, flag the string
            skip_d  = 1'b1;
            ovf_d   = 1'b1;
            pos_d   = pos_base;
            state_d = S_CHECK;
          end else begin
            skip_d          = 1'b0;
            hist_we         = 1'b1;
            cnt_req.rd_en   = 1'b1;
            cnt_req.rd_addr = s_axis_tdata[lwk_pkg::SymAw-1:0];
            pos_d           = pos_base + 1'b1;
            state_d         = S_INC;
          end
        end
      end
      S_INC: begin
        cnt_req.wr_en   = 1'b1;
        cnt_req.wr_addr = sym_q[lwk_pkg::SymAw-1:0];
        cnt_req.wdata   = cnt_val + 1'b1;
        if (cnt_val == '0) begin
          dist_d = dist_q + 1'b1;
        end
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (!skip_q && need_drop) begin
          hist_re = 1'b1;
          state_d = S_FETCH;
        end else if (can_emit) begin
          best_d      = best_new;
          out_valid_d = 1'b1;
          out_data_d  = lwk_pkg::OutW'({ovf_q, dist_q, win_len, best_new});
          state_d     = S_IDLE;
        end
      end
      S_FETCH: begin
        // hold the leaving symbol for the write back
        sym_d           = hist_rdata;
        cnt_req.rd_en   = 1'b1;
        cnt_req.rd_addr = hist_rdata[lwk_pkg::SymAw-1:0];
        state_d         = S_DROP;
      end
      S_DROP: begin
        if (cnt_val != '0) begin
          cnt_req.wr_en   = 1'b1;
          cnt_req.wr_addr = sym_q[lwk_pkg::SymAw-1:0];
          cnt_req.wdata   = cnt_val - 1'b1;
          if (cnt_val == lwk_pkg::CntW'(1)) begin
            dist_d = dist_q - 1'b1;
          end
        end
        start_d = start_q + 1'b1;
        state_d = S_CHECK;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      start_q     <= '0;
      dist_q      <= '0;
      best_q      <= '1;
      ovf_q       <= 1'b0;
      tgt_q       <= lwk_pkg::TgtW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      start_q     <= start_d;
      dist_q      <= dist_d;
      best_q      <= best_d;
      ovf_q       <= ovf_d;
      tgt_q       <= tgt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    sym_q      <= sym_d;
    skip_q     <= skip_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
